>>> design/sca_pkg.sv
// Shared types, constants and codes for the size class pool allocator.
// No dependencies.
package sca_pkg;

  localparam int ALIGN_BYTES      = 8;
  localparam int MAX_OBJECT_BYTES = 128;
  localparam int HEAP_LIMIT       = 65536;
  localparam int REFILL_RESET     = 10;
  localparam int REFILL_MAX       = 16;

  localparam int NUM_CLASSES = MAX_OBJECT_BYTES / ALIGN_BYTES;
  localparam int NUM_LINKS   = HEAP_LIMIT / ALIGN_BYTES;

  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int LINK_IDX_W  = $clog2(NUM_LINKS);
  localparam int HEAD_W      = LINK_IDX_W + 1;
  localparam int SZ_W        = $clog2(MAX_OBJECT_BYTES) + 1;
  localparam int BYTE_W      = $clog2(HEAP_LIMIT) + 1;
  localparam int CNT_W       = $clog2(REFILL_MAX) + 1;

  localparam int REQ_W       = 16;
  localparam int OFFSET_W    = 16;
  localparam int TOTAL_W     = 17;
  localparam int HEAP_CFG_W  = 17;
  localparam int REFILL_W    = 5;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_COUNT = 1'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOC     = 3'd0,
    ST_FREED     = 3'd1,
    ST_OVERSIZE  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_ZERO      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_LINK,
    S_CARVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              func;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFFSET_W-1:0] block_offset;
  } sca_in_t;

  typedef struct packed {
    status_t              status;
    logic [OFFSET_W-1:0]  granted_offset;
    logic [TOTAL_W-1:0]   listed_bytes;
  } sca_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [CLS_W-1:0]  rd_addr;
    logic              wr_en;
    logic [CLS_W-1:0]  wr_addr;
    logic [HEAD_W-1:0] wr_data;
  } head_req_t;

  typedef struct packed {
    logic                  rd_en;
    logic [LINK_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [LINK_IDX_W-1:0] wr_addr;
    logic [HEAD_W-1:0]     wr_data;
  } link_req_t;

endpackage

>>> design/sca_head_table.sv
// Per-class list heads: one small memory with a registered read and
// valid bits so that an unwritten head reads as null. Uses sca_pkg.
module sca_head_table (
  input  logic                       clk,
  input  logic                       rst,
  input  sca_pkg::head_req_t         req,
  output logic [sca_pkg::HEAD_W-1:0] rdata
);

  logic [sca_pkg::HEAD_W-1:0]      mem [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::NUM_CLASSES-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule

>>> design/sca_link_store.sv
// Next-block links of all free lists: single write port, single read port,
// registered read data. Uses sca_pkg.
module sca_link_store (
  input  logic                       clk,
  input  sca_pkg::link_req_t         req,
  output logic [sca_pkg::HEAD_W-1:0] rdata
);

  logic [sca_pkg::HEAD_W-1:0] mem [sca_pkg::NUM_LINKS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/size_class_pool_allocator_core.sv
// Top level of the size class pool allocator: sequencer, bump region and byte total.
// Depends on sca_pkg, sca_head_table and sca_link_store.
//
// One transaction is handled at a time; a finished result waits in the output
// register while the next transaction is taken. A pop from a non-empty list
// reads the head, then the link; a refill that carves n objects makes one
// link-store write for each object after the first, which is granted. No
// clearing pass after reset.
module size_class_pool_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sca_pkg::sca_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sca_pkg::sca_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0]    cfg_data
);

  sca_pkg::state_t state, state_next;

  logic                              func_q;
  logic [sca_pkg::CLS_W-1:0]         cls_q;
  logic [sca_pkg::SZ_W-1:0]          sz_q;
  logic [sca_pkg::LINK_IDX_W-1:0]    fidx_q;
  sca_pkg::status_t                  status_q;
  logic [sca_pkg::OFFSET_W-1:0]      granted_q;
  logic [sca_pkg::BYTE_W-1:0]        bump;
  logic [sca_pkg::TOTAL_W-1:0]       total;
  logic [sca_pkg::BYTE_W-1:0]        pcarve;
  logic [sca_pkg::CNT_W-1:0]         cnt;
  logic [sca_pkg::LINK_IDX_W-1:0]    prev_idx;
  logic [sca_pkg::HEAP_CFG_W-1:0]    heap_cfg;
  logic [sca_pkg::REFILL_W-1:0]      rc_cfg;

  sca_pkg::head_req_t                head_req;
  sca_pkg::link_req_t                link_req;
  logic [sca_pkg::HEAD_W-1:0]        head_rdata;
  logic [sca_pkg::HEAD_W-1:0]        link_rdata;

  logic                              accept;
  logic                              req_zero;
  logic                              req_over;
  logic [sca_pkg::REQ_W-1:0]         req_m1;
  logic [sca_pkg::CLS_W-1:0]         in_cls;
  logic [sca_pkg::BYTE_W-1:0]        end_lim;
  logic [sca_pkg::CNT_W-1:0]         rc_eff;
  logic [sca_pkg::BYTE_W:0]          bump_sum;
  logic [sca_pkg::BYTE_W:0]          carve_sum;
  logic                              bump_fits;
  logic                              carve_fits;
  logic                              head_empty;
  logic [sca_pkg::LINK_IDX_W-1:0]    pop_idx;
  logic [sca_pkg::LINK_IDX_W-1:0]    p_idx;
  logic [sca_pkg::TOTAL_W:0]         add_sum;
  logic [sca_pkg::TOTAL_W-1:0]       total_add;
  logic [sca_pkg::TOTAL_W-1:0]       total_sub;
  logic                              finish_load;

  sca_head_table u_heads (
    .clk   (clk),
    .rst   (rst),
    .req   (head_req),
    .rdata (head_rdata)
  );

  sca_link_store u_links (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rdata)
  );

  assign accept    = in_valid && in_ready;
  assign req_zero  = (in_data.request_bytes == '0);
  assign req_over  = (in_data.request_bytes > sca_pkg::REQ_W'(sca_pkg::MAX_OBJECT_BYTES));
  assign req_m1    = in_data.request_bytes - 1'b1;
  assign in_cls    = sca_pkg::CLS_W'(req_m1 >> sca_pkg::ALIGN_SHIFT);

  assign end_lim = (heap_cfg > sca_pkg::HEAP_CFG_W'(sca_pkg::HEAP_LIMIT)) ?
                   sca_pkg::BYTE_W'(sca_pkg::HEAP_LIMIT) : sca_pkg::BYTE_W'(heap_cfg);
  assign rc_eff  = (rc_cfg == '0) ? sca_pkg::CNT_W'(1) :
                   (rc_cfg > sca_pkg::REFILL_W'(sca_pkg::REFILL_MAX)) ?
                   sca_pkg::CNT_W'(sca_pkg::REFILL_MAX) : sca_pkg::CNT_W'(rc_cfg);

  assign bump_sum   = {1'b0, bump} + (sca_pkg::BYTE_W + 1)'(sz_q);
  assign carve_sum  = {1'b0, pcarve} + (sca_pkg::BYTE_W + 1)'(sz_q);
  assign bump_fits  = (bump_sum <= {1'b0, end_lim});
  assign carve_fits = (cnt < rc_eff) && (carve_sum <= {1'b0, end_lim});
  assign head_empty = (head_rdata == '0);
  assign pop_idx    = sca_pkg::LINK_IDX_W'(head_rdata - 1'b1);
  assign p_idx      = sca_pkg::LINK_IDX_W'(pcarve >> sca_pkg::ALIGN_SHIFT);

  assign add_sum   = {1'b0, total} + (sca_pkg::TOTAL_W + 1)'(sz_q);
  assign total_add = (add_sum > {1'b0, sca_pkg::TOTAL_MAX}) ?
                     sca_pkg::TOTAL_MAX : add_sum[sca_pkg::TOTAL_W-1:0];
  assign total_sub = (total > sca_pkg::TOTAL_W'(sz_q)) ?
                     total - sca_pkg::TOTAL_W'(sz_q) : '0;

  assign finish_load = (state == sca_pkg::S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      sca_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (req_zero || req_over) ? sca_pkg::S_FINISH : sca_pkg::S_HEAD;
        end
      end
      sca_pkg::S_HEAD: begin
        if (func_q == sca_pkg::FUNC_FREE) begin
          state_next = sca_pkg::S_FINISH;
        end else if (!head_empty) begin
          state_next = sca_pkg::S_LINK;
        end else if (bump_fits) begin
          state_next = sca_pkg::S_CARVE;
        end else begin
          state_next = sca_pkg::S_FINISH;
        end
      end
      sca_pkg::S_LINK: begin
        state_next = sca_pkg::S_FINISH;
      end
      sca_pkg::S_CARVE: begin
        if (!carve_fits) begin
          state_next = sca_pkg::S_FINISH;
        end
      end
      sca_pkg::S_FINISH: begin
        if (finish_load) begin
          state_next = sca_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sca_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    head_req = '0;
    link_req = '0;
    head_req.rd_addr = in_cls;
    head_req.wr_addr = cls_q;
    case (state)
      sca_pkg::S_IDLE: begin
        in_ready       = 1'b1;
        head_req.rd_en = accept && !req_zero && !req_over;
      end
      sca_pkg::S_HEAD: begin
        if (func_q == sca_pkg::FUNC_FREE) begin
          link_req.wr_en   = 1'b1;
          link_req.wr_addr = fidx_q;
          link_req.wr_data = head_rdata;
          head_req.wr_en   = 1'b1;
          head_req.wr_data = sca_pkg::HEAD_W'(fidx_q) + 1'b1;
        end else if (!head_empty) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = pop_idx;
        end
      end
      sca_pkg::S_LINK: begin
        head_req.wr_en   = 1'b1;
        head_req.wr_data = link_rdata;
      end
      sca_pkg::S_CARVE: begin
        link_req.wr_en   = (cnt > sca_pkg::CNT_W'(1));
        link_req.wr_addr = prev_idx;
        link_req.wr_data = carve_fits ? sca_pkg::HEAD_W'(p_idx) + 1'b1 : '0;
        head_req.wr_en   = carve_fits && (cnt == sca_pkg::CNT_W'(1));
        head_req.wr_data = sca_pkg::HEAD_W'(p_idx) + 1'b1;
      end
      sca_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sca_pkg::S_IDLE;
      bump      <= '0;
      total     <= '0;
      heap_cfg  <= sca_pkg::HEAP_CFG_W'(sca_pkg::HEAP_LIMIT);
      rc_cfg    <= sca_pkg::REFILL_W'(sca_pkg::REFILL_RESET);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          sca_pkg::CFG_HEAP_BYTES:   heap_cfg <= cfg_data;
          sca_pkg::CFG_REFILL_COUNT: rc_cfg   <= sca_pkg::REFILL_W'(cfg_data);
          default: begin
          end
        endcase
      end
      case (state)
        sca_pkg::S_HEAD: begin
          if (func_q == sca_pkg::FUNC_FREE) begin
            total <= total_add;
          end
        end
        sca_pkg::S_LINK: begin
          total <= total_sub;
        end
        sca_pkg::S_CARVE: begin
          if (carve_fits) begin
            total <= total_add;
          end else begin
            bump <= pcarve;
          end
        end
        default: begin
        end
      endcase
      if (finish_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sca_pkg::S_IDLE: begin
        if (accept) begin
          func_q    <= in_data.func;
          cls_q     <= in_cls;
          sz_q      <= sca_pkg::SZ_W'((sca_pkg::SZ_W'(in_cls) + 1'b1) << sca_pkg::ALIGN_SHIFT);
          fidx_q    <= sca_pkg::LINK_IDX_W'(in_data.block_offset >> sca_pkg::ALIGN_SHIFT);
          granted_q <= '0;
          status_q  <= req_zero ? sca_pkg::ST_ZERO : sca_pkg::ST_OVERSIZE;
        end
      end
      sca_pkg::S_HEAD: begin
        if (func_q == sca_pkg::FUNC_FREE) begin
          status_q <= sca_pkg::ST_FREED;
        end else if (!head_empty) begin
          status_q  <= sca_pkg::ST_ALLOC;
          granted_q <= sca_pkg::OFFSET_W'(pop_idx) << sca_pkg::ALIGN_SHIFT;
        end else if (bump_fits) begin
          status_q  <= sca_pkg::ST_ALLOC;
          granted_q <= sca_pkg::OFFSET_W'(bump);
          pcarve    <= sca_pkg::BYTE_W'(bump_sum);
          cnt       <= sca_pkg::CNT_W'(1);
        end else begin
          status_q <= sca_pkg::ST_EXHAUSTED;
        end
      end
      sca_pkg::S_CARVE: begin
        if (carve_fits) begin
          prev_idx <= p_idx;
          pcarve   <= sca_pkg::BYTE_W'(carve_sum);
          cnt      <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (finish_load) begin
      out_data.status         <= status_q;
      out_data.granted_offset <= granted_q;
      out_data.listed_bytes   <= total;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("transaction taken while another is in progress");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == sca_pkg::ST_ALLOC || out_data.granted_offset == '0))
    else $error("non-zero offset on a failed or free transaction");

  a_bump_in_heap: assert property (@(posedge clk) disable iff (rst)
    bump <= sca_pkg::BYTE_W'(sca_pkg::HEAP_LIMIT))
    else $error("bump region ran past the heap limit");

  a_carve_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sca_pkg::S_CARVE) |-> (cnt <= rc_eff))
    else $error("refill carved more objects than allowed");

endmodule

>>> sim/size_class_pool_allocator_core_tb.sv
// Testbench for size_class_pool_allocator_core: random and directed allocate/free traffic
// checked against a cycle-free shadow of the free lists, bump region and byte total.
// Depends on sca_pkg and the core RTL only.
module size_class_pool_allocator_core_tb;
  import sca_pkg::*;

  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;

  class heap_shadow;
    int unsigned list_head [NUM_CLASSES];
    int unsigned next_link [NUM_LINKS];
    int unsigned carve_ptr;
    int unsigned listed_total;
    int unsigned heap_end;
    int unsigned refill_n;
    int unsigned errors;
    sca_out_t awaited_replies [$];

    function new();
      heap_end = HEAP_LIMIT;
      refill_n = REFILL_RESET;
      carve_ptr = 0;
      listed_total = 0;
      errors = 0;
      foreach (list_head[i]) list_head[i] = 0;
      foreach (next_link[i]) next_link[i] = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_HEAP_BYTES) heap_end = value[HEAP_CFG_W-1:0];
      else refill_n = value[REFILL_W-1:0];
    endfunction

    function void grow(int unsigned v);
      listed_total = (listed_total + v > TOTAL_MAX) ? TOTAL_MAX : listed_total + v;
    endfunction

    function void shrink(int unsigned v);
      listed_total = (listed_total > v) ? listed_total - v : 0;
    endfunction

    function sca_out_t take_request(sca_in_t t);
      sca_out_t r;
      int unsigned req, cls, sz, idx, lim, left, n, first, step, cur;
      req = t.request_bytes;
      r.granted_offset = '0;
      if (req == 0) begin
        r.status = ST_ZERO;
      end else if (req > MAX_OBJECT_BYTES) begin
        r.status = ST_OVERSIZE;
      end else begin
        cls = (req + ALIGN_BYTES - 1) / ALIGN_BYTES - 1;
        sz = (cls + 1) * ALIGN_BYTES;
        if (t.func == FUNC_FREE) begin
          idx = t.block_offset / ALIGN_BYTES;
          r.status = ST_FREED;
          if (idx < NUM_LINKS) begin
            next_link[idx] = list_head[cls];
            list_head[cls] = idx + 1;
            grow(sz);
          end
        end else if (list_head[cls] != 0) begin
          idx = list_head[cls] - 1;
          list_head[cls] = next_link[idx];
          r.granted_offset = idx * ALIGN_BYTES;
          shrink(sz);
          r.status = ST_ALLOC;
        end else begin
          lim = (heap_end > HEAP_LIMIT) ? HEAP_LIMIT : heap_end;
          left = (lim > carve_ptr) ? lim - carve_ptr : 0;
          n = refill_n;
          if (n == 0) n = 1;
          if (n > REFILL_MAX) n = REFILL_MAX;
          if (left < sz) begin
            r.status = ST_EXHAUSTED;
          end else begin
            if (left < sz * n) n = left / sz;
            r.granted_offset = carve_ptr;
            if (n > 1) begin
              first = (carve_ptr + sz) / ALIGN_BYTES;
              step = sz / ALIGN_BYTES;
              list_head[cls] = first + 1;
              for (int unsigned k = 0; k + 1 < n; k++) begin
                cur = first + k * step;
                next_link[cur] = (k + 2 < n) ? cur + step + 1 : 0;
              end
              grow((n - 1) * sz);
            end
            carve_ptr += n * sz;
            r.status = ST_ALLOC;
          end
        end
      end
      r.listed_bytes = listed_total[TOTAL_W-1:0];
      awaited_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(sca_out_t got);
      sca_out_t want;
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with none awaited: status %0d offset %0d bytes %0d",
                 $time, got.status, got.granted_offset, got.listed_bytes);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.granted_offset !== want.granted_offset) begin
        errors++;
        $display("%0t: granted_offset expected %0d actual %0d",
                 $time, want.granted_offset, got.granted_offset);
      end
      if (got.listed_bytes !== want.listed_bytes) begin
        errors++;
        $display("%0t: listed_bytes expected %0d actual %0d",
                 $time, want.listed_bytes, got.listed_bytes);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  sca_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sca_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  heap_shadow  shadow = new();
  int unsigned send_idle = IDLE_PCT;
  int unsigned recv_idle = IDLE_PCT;
  int unsigned quiet_cycles = 0;
  int unsigned live_offset [$];
  int unsigned live_size [$];

  size_class_pool_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) shadow.check_reply(out_data);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_size(int unsigned cls);
    return $urandom_range((cls + 1) * ALIGN_BYTES, cls * ALIGN_BYTES + 1);
  endfunction

  // hold valid and payload until the transaction is taken
  task automatic issue(logic func, int unsigned size, int unsigned offset);
    sca_in_t  t;
    sca_out_t p;
    t.func = func;
    t.request_bytes = size[REQ_W-1:0];
    t.block_offset = offset[OFFSET_W-1:0];
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    p = shadow.take_request(t);
    if (func == FUNC_ALLOC && p.status == ST_ALLOC) begin
      live_offset.push_back(p.granted_offset);
      live_size.push_back(size);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (shadow.awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    shadow.apply_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_mix(int unsigned count, int unsigned free_pct);
    int unsigned roll, j, off, size;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        case ($urandom_range(3))
          0: issue($urandom_range(1), 0, $urandom);
          1: issue($urandom_range(1), $urandom_range(65535, MAX_OBJECT_BYTES + 1), $urandom);
          2: issue(FUNC_FREE, $urandom_range(MAX_OBJECT_BYTES, 1), $urandom);
          default: issue(FUNC_ALLOC, $urandom_range(MAX_OBJECT_BYTES, 1), $urandom);
        endcase
      end else if (live_offset.size() != 0 && roll < 10 + free_pct) begin
        j = $urandom_range(live_offset.size() - 1);
        off = live_offset[j];
        if ($urandom_range(3) == 0) off += $urandom_range(ALIGN_BYTES - 1);
        size = pick_size((live_size[j] + ALIGN_BYTES - 1) / ALIGN_BYTES - 1);
        live_offset.delete(j);
        live_size.delete(j);
        issue(FUNC_FREE, size, off);
      end else begin
        issue(FUNC_ALLOC, $urandom_range(MAX_OBJECT_BYTES, 1), $urandom);
      end
    end
  endtask

  initial begin
    int unsigned cls;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue(FUNC_ALLOC, 0, 16'hFFFF);
    issue(FUNC_FREE, 0, 0);
    issue(FUNC_ALLOC, MAX_OBJECT_BYTES + 1, 0);
    issue(FUNC_FREE, 16'hFFFF, 16'hFFFF);
    issue(FUNC_ALLOC, 16'h8000, 0);
    issue(FUNC_ALLOC, MAX_OBJECT_BYTES, 0);
    issue(FUNC_ALLOC, 1, 0);
    issue(FUNC_ALLOC, ALIGN_BYTES, 0);
    issue(FUNC_ALLOC, ALIGN_BYTES + 1, 0);
    issue(FUNC_FREE, MAX_OBJECT_BYTES, 0);
    issue(FUNC_ALLOC, MAX_OBJECT_BYTES - 7, 0);
    issue(FUNC_FREE, 1, 16'hFFFF);
    issue(FUNC_ALLOC, 5, 0);
    issue(FUNC_FREE, 2 * ALIGN_BYTES, 3);
    issue(FUNC_ALLOC, 2 * ALIGN_BYTES, 0);
    issue(FUNC_FREE, MAX_OBJECT_BYTES, 16'h5555);
    issue(FUNC_ALLOC, MAX_OBJECT_BYTES, 16'hAAAA);

    settle();
    set_reg(CFG_REFILL_COUNT, 0);
    run_mix(30, 35);

    // long stretch with both sides flat out
    settle();
    set_reg(CFG_REFILL_COUNT, 31);
    send_idle = 0;
    recv_idle = 0;
    run_mix(150, 35);
    send_idle = IDLE_PCT;
    recv_idle = IDLE_PCT;

    // leave only a few objects' worth of bump region
    settle();
    set_reg(CFG_REFILL_COUNT, REFILL_MAX);
    set_reg(CFG_HEAP_BYTES, shadow.carve_ptr + 3 * MAX_OBJECT_BYTES + 40);
    run_mix(100, 30);

    settle();
    set_reg(CFG_HEAP_BYTES, 0);
    run_mix(50, 40);

    settle();
    set_reg(CFG_HEAP_BYTES, 131071);
    set_reg(CFG_REFILL_COUNT, 1);
    run_mix(120, 35);

    settle();
    set_reg(CFG_REFILL_COUNT, $urandom_range(REFILL_MAX - 1, 2));
    set_reg(CFG_HEAP_BYTES, HEAP_LIMIT);
    run_mix(150, 45);

    // push the byte total to its ceiling, then pop it down to the floor
    settle();
    set_reg(CFG_REFILL_COUNT, REFILL_MAX);
    while (shadow.listed_total < TOTAL_MAX)
      issue(FUNC_FREE, pick_size(NUM_CLASSES - 1), $urandom & ~(MAX_OBJECT_BYTES - 1));
    repeat (8) issue(FUNC_FREE, pick_size(NUM_CLASSES - 1), $urandom);
    while (shadow.listed_total != 0) begin
      cls = NUM_CLASSES - 1;
      while (cls != 0 && shadow.list_head[cls] == 0) cls--;
      issue(FUNC_ALLOC, pick_size(cls), 0);
    end
    repeat (8) issue(FUNC_ALLOC, $urandom_range(MAX_OBJECT_BYTES, 1), 0);

    settle();
    if (shadow.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sca_pkg.sv
design/sca_head_table.sv
design/sca_link_store.sv
design/size_class_pool_allocator_core.sv
sim/size_class_pool_allocator_core_tb.sv
